[rtl/core/lpdd_pkg.sv]
// ----------------------------------------------------------------------------
// lpdd_pkg
// Shared constants and types for the rotating range-sensor packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lpdd_pkg;

  // Distance table geometry
  localparam int NUM_ANGLES = 360;
  localparam int ADDR_W     = (NUM_ANGLES > 1) ? $clog2(NUM_ANGLES) : 1;
  localparam int CMP_W      = 11;  // wide enough to compare angles with NUM_ANGLES

  // Packet framing
  localparam int PACKET_LEN = 22;
  localparam int BUF_LAST   = PACKET_LEN - 2;  // highest buffered byte position
  localparam logic [4:0] CLOSE_POS = 5'(PACKET_LEN - 1);

  localparam logic [7:0] START_BYTE  = 8'hFA;
  localparam logic [7:0] FIRST_INDEX = 8'hA0;
  localparam logic [7:0] INDEX_LIMIT = 8'hF9;
  localparam logic [7:0] INDEX_WRAP  = 8'h9F;

  localparam logic [13:0] MAX_DIST_RST = 14'd6000;

  // Input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Result kinds
  localparam logic KIND_READING = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  // Register word address
  localparam logic REG_MAX_DIST = 1'b0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DECODE
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [8:0]  angle;
    logic [13:0] distance;
    logic        invalid_mark;
    logic [15:0] speed_raw;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/lidar_packet_distance_decoder_top.sv]
// ----------------------------------------------------------------------------
// lidar_packet_distance_decoder_top
// Frames sensor serial bytes into packets, decodes four readings per packet
// into a distance table memory and answers table read requests.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ---------------------------------
//  in       input      in_valid / in_stall  action, rx_byte, read_angle
//  out      output     out_valid/out_stall  kind, angle, distance,
//                                           invalid_mark, speed_raw, last
//  cfg      input      APB (pready = 1)     max_distance at byte address 0
//
//  Bytes and reads are taken one per cycle, back to back, while in_stall is low.
//  A closing byte whose index follows the last one starts a decode, one reading
//  per step (held while the queue is full): the four readings go through the one table write port, input stalled.
//  Read replies pass the registered memory read port and then the result queue.
//  After reset a sweep zeroes all NUM_ANGLES (360) table entries, input stalled.
//  A 2-entry result queue decouples out_stall; reads stall when it is full.
//
`default_nettype none

module lidar_packet_distance_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [8:0]  in_read_angle,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [8:0]       out_angle,
  output logic [13:0]      out_distance,
  output logic             out_invalid_mark,
  output logic [15:0]      out_speed_raw,
  output logic             out_last,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = lpdd_pkg::ADDR_W;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [13:0] max_dist_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= lpdd_pkg::MAX_DIST_RST;
    end else if (psel && penable && pwrite && (paddr[2] == lpdd_pkg::REG_MAX_DIST)) begin
      max_dist_r <= pwdata[13:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lpdd_pkg::REG_MAX_DIST) begin
      prdata = {18'd0, max_dist_r};
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  lpdd_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r;
  logic [1:0]       dec_k_r, dec_k_nxt;

  logic             receiving_r;
  logic [4:0]       byte_cnt_r;
  logic [7:0]       pkt_r [1:lpdd_pkg::BUF_LAST];
  logic [7:0]       last_num_r;
  logic [15:0]      speed_r;

  // result queue
  lpdd_pkg::res_t   fifo_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;

  // pending read reply
  logic             rd_pend_r;
  logic [8:0]       rd_angle_r;
  logic             rd_oob_r;
  logic [13:0]      rd_q_r;

  // distance table
  logic [13:0]      dist_mem [lpdd_pkg::NUM_ANGLES];

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic       pop, push, in_fire, byte_fire, read_fire, rd_room, dec_go;
  logic [2:0] occ;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  // a read reply lands next cycle: leave a queue slot for it
  assign occ     = {1'b0, cnt_r} + {2'b0, rd_pend_r};
  assign rd_room = (occ <= ({2'b0, pop} + 3'd1));

  assign in_stall  = (state_r != lpdd_pkg::ST_RUN) ||
                     ((in_action == lpdd_pkg::ACT_READ) && !rd_room);
  assign in_fire   = in_valid && !in_stall;
  assign byte_fire = in_fire && (in_action == lpdd_pkg::ACT_BYTE);
  assign read_fire = in_fire && (in_action == lpdd_pkg::ACT_READ);

  // decoder steps only when the queue has a free slot
  assign dec_go = (state_r == lpdd_pkg::ST_DECODE) && ((cnt_r < 2'd2) || pop);

  // --------------------------------------------------------------------------
  // Framing
  // --------------------------------------------------------------------------
  logic close, matched, pkt_wr, start;

  assign close   = byte_fire && receiving_r && (byte_cnt_r >= lpdd_pkg::CLOSE_POS);
  assign matched = ({1'b0, pkt_r[1]} == ({1'b0, last_num_r} + 9'd1));
  assign pkt_wr  = byte_fire && receiving_r && !close;
  // closing byte may itself open the next packet
  assign start   = byte_fire && (!receiving_r || close) &&
                   (in_rx_byte == lpdd_pkg::START_BYTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      byte_cnt_r  <= 5'd0;
      last_num_r  <= lpdd_pkg::INDEX_WRAP;
      speed_r     <= 16'd0;
    end else begin
      if (start) begin
        receiving_r <= 1'b1;
        byte_cnt_r  <= 5'd1;
      end else if (close) begin
        receiving_r <= 1'b0;
      end else if (pkt_wr) begin
        byte_cnt_r <= byte_cnt_r + 5'd1;
      end
      if (close) begin
        last_num_r <= (pkt_r[1] >= lpdd_pkg::INDEX_LIMIT) ? lpdd_pkg::INDEX_WRAP : pkt_r[1];
        if (matched) begin
          speed_r <= {pkt_r[3], pkt_r[2]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_wr) begin
      pkt_r[byte_cnt_r] <= in_rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Reading decode (one reading per step)
  // --------------------------------------------------------------------------
  logic [7:0]  lo_b, hi_b, a_off;
  logic [8:0]  dec_angle;
  logic [13:0] raw_d, dec_dist;
  logic        in_range, dec_last, dec_inv;

  always_comb begin
    case (dec_k_r)
      2'd0:    begin lo_b = pkt_r[4];  hi_b = pkt_r[5];  end
      2'd1:    begin lo_b = pkt_r[8];  hi_b = pkt_r[9];  end
      2'd2:    begin lo_b = pkt_r[12]; hi_b = pkt_r[13]; end
      2'd3:    begin lo_b = pkt_r[16]; hi_b = pkt_r[17]; end
      default: begin lo_b = pkt_r[4];  hi_b = pkt_r[5];  end
    endcase
  end

  assign a_off     = pkt_r[1] - lpdd_pkg::FIRST_INDEX;
  assign dec_angle = {a_off[6:0], dec_k_r};
  assign in_range  = (pkt_r[1] >= lpdd_pkg::FIRST_INDEX) &&
                     ({2'b0, dec_angle} < lpdd_pkg::CMP_W'(lpdd_pkg::NUM_ANGLES));
  assign dec_last  = (dec_k_r == 2'd3) ||
                     (({2'b0, dec_angle} + 11'd1) >= lpdd_pkg::CMP_W'(lpdd_pkg::NUM_ANGLES));
  assign dec_inv   = hi_b[7];
  assign raw_d     = {hi_b[5:0], lo_b};
  assign dec_dist  = (dec_inv || (raw_d > max_dist_r)) ? 14'd0 : raw_d;

  // --------------------------------------------------------------------------
  // Sequencer: clear sweep, run, decode
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    dec_k_nxt = dec_k_r;
    case (state_r)
      lpdd_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(lpdd_pkg::NUM_ANGLES - 1)) begin
          state_nxt = lpdd_pkg::ST_RUN;
        end
      end
      lpdd_pkg::ST_RUN: begin
        if (close && matched) begin
          state_nxt = lpdd_pkg::ST_DECODE;
          dec_k_nxt = 2'd0;
        end
      end
      lpdd_pkg::ST_DECODE: begin
        if (dec_go) begin
          dec_k_nxt = dec_k_r + 2'd1;
          if (dec_k_r == 2'd3) begin
            state_nxt = lpdd_pkg::ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = lpdd_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lpdd_pkg::ST_CLEAR;
      clr_addr_r <= '0;
      dec_k_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      dec_k_r <= dec_k_nxt;
      if (state_r == lpdd_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Distance table memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic          we;
  logic [AW-1:0] waddr;
  logic [13:0]   wdata;

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr_r;
    wdata = 14'd0;
    if (state_r == lpdd_pkg::ST_CLEAR) begin
      we = 1'b1;
    end else if (dec_go && in_range) begin
      we    = 1'b1;
      waddr = AW'(dec_angle);
      wdata = dec_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      dist_mem[waddr] <= wdata;
    end
    if (read_fire) begin
      rd_q_r <= dist_mem[AW'(in_read_angle)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= read_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      rd_angle_r <= in_read_angle;
      rd_oob_r   <= ({2'b0, in_read_angle} >= lpdd_pkg::CMP_W'(lpdd_pkg::NUM_ANGLES));
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  lpdd_pkg::res_t push_res;

  // reply push and decoder push never coincide: decode starts only after a closing
  // byte, so a reply pending from an earlier read is pushed before it
  assign push = rd_pend_r || (dec_go && in_range);

  always_comb begin
    if (rd_pend_r) begin
      push_res.kind         = lpdd_pkg::KIND_REPLY;
      push_res.angle        = rd_angle_r;
      push_res.distance     = rd_oob_r ? 14'd0 : rd_q_r;
      push_res.invalid_mark = 1'b0;
      push_res.speed_raw    = speed_r;
      push_res.last         = 1'b1;
    end else begin
      push_res.kind         = lpdd_pkg::KIND_READING;
      push_res.angle        = dec_angle;
      push_res.distance     = dec_dist;
      push_res.invalid_mark = dec_inv;
      push_res.speed_raw    = speed_r;
      push_res.last         = dec_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_res;
    end
  end

  lpdd_pkg::res_t head;
  assign head = fifo_r[rd_ptr_r];

  assign out_kind         = head.kind;
  assign out_angle        = head.angle;
  assign out_distance     = head.distance;
  assign out_invalid_mark = head.invalid_mark;
  assign out_speed_raw    = head.speed_raw;
  assign out_last         = head.last;

endmodule

`default_nettype wire
